### hw/rtl/ssdp_pkg.sv
`timescale 1ns / 1ps
// Package for the staffing dynamic program unit: sizes, codes, payload types
// and the saturating helper. Used by every module in hw/rtl.
package ssdp_pkg;

    localparam int MAX_LEVELS  = 32;
    localparam int MAX_PERIODS = 16;
    localparam int PER_PERIOD  = MAX_LEVELS * (MAX_LEVELS + 1) / 2;
    localparam int TURN_DEPTH  = MAX_PERIODS * PER_PERIOD;
    localparam int ADDR_W      = $clog2(TURN_DEPTH);
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int PER_W       = $clog2(MAX_PERIODS);
    localparam int COST_W      = 48;
    localparam int PROB_W      = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [PROB_W-1:0] ONE_Q16  = PROB_W'(65536);

    typedef enum logic [1:0] {
        OP_LOAD_PROB = 2'd0,
        OP_LOAD_MIN  = 2'd1,
        OP_SOLVE     = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIXED_HIRE  = 3'd0,
        CFG_HIRE_UNIT   = 3'd1,
        CFG_SALARY      = 3'd2,
        CFG_SHORTAGE    = 3'd3,
        CFG_STAFF_CAP   = 3'd4,
        CFG_HIRE_CAP    = 3'd5,
        CFG_PERIODS     = 3'd6,
        CFG_INIT_STAFF  = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PSTART,
        ST_E_RD,
        ST_E_C,
        ST_E_MUL,
        ST_E_ACC,
        ST_H_RD0,
        ST_H_LD0,
        ST_H_RD,
        ST_H_CMP,
        ST_H_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [3:0]        period;
        logic [4:0]        staff_before;
        logic [4:0]        leavers;
        logic [PROB_W-1:0] probability;
        logic [4:0]        min_staff;
    } in_item_t;

    typedef struct packed {
        logic [COST_W-1:0] optimal_cost;
        logic [4:0]        first_hire;
    } out_item_t;

    function automatic logic [COST_W-1:0] sat_cost(input logic [COST_W:0] v);
        sat_cost = v[COST_W] ? COST_MAX : v[COST_W-1:0];
    endfunction

endpackage

### hw/rtl/stochastic_staffing_dp_unit.sv
`timescale 1ns / 1ps
// Top level of the staffing dynamic program: tables, sequencer and result
// register. Depends on ssdp_pkg and ssdp_weigh.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    in_item_t
//  m_        out        m_valid / m_ready    out_item_t
//  cfg_      in         cfg_we               cfg_index, cfg_wdata
//
// A load is written when accepted, so a new request can follow it directly. A solve
// runs, for each period from the last down, the expected-cost pass over staff levels
// up to the staff cap and then the hiring pass over hire counts up to the hire cap.
// The result holds in ST_DONE while the output register is stalled. s_ready stays
// low during a solve.
// Reset is synchronous, active low; tables are not cleared.
module stochastic_staffing_dp_unit import ssdp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [15:0] fixed_reg, unit_reg, salary_reg, penalty_reg;
    logic [4:0]  staff_cap_reg, hire_cap_reg, periods_reg, init_reg;

    logic [PROB_W-1:0] turn_mem [TURN_DEPTH];
    logic [COST_W-1:0] cost_mem [2*MAX_LEVELS];
    logic [COST_W-1:0] exp_mem  [MAX_LEVELS];
    logic [4:0]        min_reg  [MAX_PERIODS];

    state_t state_reg, state_next;
    logic [PER_W-1:0]  t_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LVL_W-1:0]  y_reg, i_reg, x_reg, a_reg, lvl_reg, cap, init_c;
    logic [4:0]        mn_reg, best_a_reg, first_hire_reg;
    logic              nxt_reg, first_reg, m_valid_reg;
    logic [COST_W-1:0] tq_reg, ctg_reg, exq_reg, c_reg, acc_reg, best_reg;
    logic [COST_W-1:0] result_reg, weighted, acc_new, v_cost;
    logic [PROB_W-1:0] p_reg;
    out_item_t         m_data_reg;

    logic              s_acc, load_prob_ok, weigh_en;
    logic [4:0]        periods_c;
    logic [10:0]       tri_n;
    logic [ADDR_W-1:0] load_addr, period_base;
    logic [5:0]        xa;
    logic [LVL_W-1:0]  h_lvl, exp_raddr;
    logic [4:0]        short_by;
    logic [21:0]       imm_raw, h_raw;
    logic [PROB_W-1:0] prob_clamp;

    assign cap       = staff_cap_reg;
    assign init_c    = (init_reg > cap) ? cap : init_reg;
    assign periods_c = (periods_reg > 5'(MAX_PERIODS)) ? 5'(MAX_PERIODS) : periods_reg;
    assign s_acc     = s_valid && s_ready;
    assign tri_n     = (11'(s_data.staff_before) * (11'(s_data.staff_before) + 11'd1)) >> 1;
    assign load_addr = ADDR_W'(s_data.period) * ADDR_W'(PER_PERIOD) + ADDR_W'(tri_n)
                       + ADDR_W'(s_data.leavers);
    assign load_prob_ok = s_data.leavers <= s_data.staff_before;
    assign prob_clamp   = (s_data.probability > ONE_Q16) ? ONE_Q16 : s_data.probability;
    assign period_base  = ADDR_W'(t_reg) * ADDR_W'(PER_PERIOD);
    assign xa        = 6'(x_reg) + 6'(a_reg);
    assign h_lvl     = (xa > 6'(cap)) ? cap : xa[LVL_W-1:0];
    assign exp_raddr = (state_reg == ST_H_RD0) ? x_reg : h_lvl;
    assign short_by  = (mn_reg > 5'(lvl_reg)) ? mn_reg - 5'(lvl_reg) : 5'd0;
    assign imm_raw   = 22'(salary_reg) * 22'(lvl_reg) + 22'(penalty_reg) * 22'(short_by);
    assign h_raw     = 22'(fixed_reg) + 22'(unit_reg) * 22'(a_reg);
    assign acc_new   = sat_cost((COST_W+1)'(acc_reg) + (COST_W+1)'(weighted));
    assign v_cost    = sat_cost((COST_W+1)'({h_raw, 16'd0}) + (COST_W+1)'(exq_reg));

    ssdp_weigh u_weigh (
        .aclk     (aclk),
        .en       (weigh_en),
        .prob     (p_reg),
        .cost     (c_reg),
        .weighted (weighted)
    );

    always_comb begin
        s_ready  = 1'b0;
        weigh_en = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready  = 1'b1;
            ST_E_MUL: weigh_en = 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_acc && s_data.operation == OP_SOLVE) begin
                    state_next = (periods_c == 5'd0) ? ST_DONE : ST_PSTART;
                end
            ST_PSTART: state_next = ST_E_RD;
            ST_E_RD:   state_next = ST_E_C;
            ST_E_C:    state_next = ST_E_MUL;
            ST_E_MUL:  state_next = ST_E_ACC;
            ST_E_ACC:
                if (i_reg == y_reg && y_reg == cap) begin
                    state_next = ST_H_RD0;
                end else begin
                    state_next = ST_E_RD;
                end
            ST_H_RD0:  state_next = ST_H_LD0;
            ST_H_LD0:  state_next = (hire_cap_reg == 5'd0) ? ST_H_WR : ST_H_RD;
            ST_H_RD:   state_next = ST_H_CMP;
            ST_H_CMP:  state_next = (5'(a_reg) == hire_cap_reg) ? ST_H_WR : ST_H_RD;
            ST_H_WR:
                if (x_reg == cap) begin
                    state_next = (t_reg == '0) ? ST_DONE : ST_PSTART;
                end else begin
                    state_next = ST_H_RD0;
                end
            ST_DONE:
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            fixed_reg     <= '0;
            unit_reg      <= '0;
            salary_reg    <= '0;
            penalty_reg   <= '0;
            staff_cap_reg <= 5'd31;
            hire_cap_reg  <= 5'd31;
            periods_reg   <= 5'd1;
            init_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FIXED_HIRE: fixed_reg     <= cfg_wdata;
                    CFG_HIRE_UNIT:  unit_reg      <= cfg_wdata;
                    CFG_SALARY:     salary_reg    <= cfg_wdata;
                    CFG_SHORTAGE:   penalty_reg   <= cfg_wdata;
                    CFG_STAFF_CAP:  staff_cap_reg <= cfg_wdata[4:0];
                    CFG_HIRE_CAP:   hire_cap_reg  <= cfg_wdata[4:0];
                    CFG_PERIODS:    periods_reg   <= cfg_wdata[4:0];
                    CFG_INIT_STAFF: init_reg      <= cfg_wdata[4:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.operation == OP_LOAD_PROB && load_prob_ok) begin
            turn_mem[load_addr] <= prob_clamp;
        end
        if (s_acc && s_data.operation == OP_LOAD_MIN) begin
            min_reg[s_data.period] <= s_data.min_staff;
        end
        tq_reg  <= COST_W'(turn_mem[addr_reg]);
        ctg_reg <= cost_mem[{nxt_reg, lvl_reg}];
        exq_reg <= exp_mem[exp_raddr];
        if (state_reg == ST_E_ACC && i_reg == y_reg) begin
            exp_mem[y_reg] <= acc_new;
        end
        if (state_reg == ST_H_WR) begin
            cost_mem[{~nxt_reg, x_reg}] <= best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE:
                if (s_acc && s_data.operation == OP_SOLVE) begin
                    t_reg          <= PER_W'(periods_c - 5'd1);
                    nxt_reg        <= 1'b0;
                    first_reg      <= 1'b1;
                    result_reg     <= '0;
                    first_hire_reg <= '0;
                end
            ST_PSTART: begin
                addr_reg <= period_base;
                y_reg    <= '0;
                i_reg    <= '0;
                acc_reg  <= '0;
                lvl_reg  <= '0;
                mn_reg   <= min_reg[t_reg];
            end
            ST_E_C: begin
                p_reg <= tq_reg[PROB_W-1:0];
                c_reg <= sat_cost((COST_W+1)'({imm_raw, 16'd0})
                                  + (COST_W+1)'(first_reg ? '0 : ctg_reg));
            end
            ST_E_ACC: begin
                addr_reg <= addr_reg + ADDR_W'(1);
                if (i_reg == y_reg) begin
                    y_reg   <= y_reg + LVL_W'(1);
                    i_reg   <= '0;
                    acc_reg <= '0;
                    lvl_reg <= y_reg + LVL_W'(1);
                    x_reg   <= '0;
                end else begin
                    i_reg   <= i_reg + LVL_W'(1);
                    acc_reg <= acc_new;
                    lvl_reg <= lvl_reg - LVL_W'(1);
                end
            end
            ST_H_LD0: begin
                best_reg   <= exq_reg;
                best_a_reg <= '0;
                a_reg      <= LVL_W'(1);
            end
            ST_H_CMP: begin
                if (v_cost < best_reg) begin
                    best_reg   <= v_cost;
                    best_a_reg <= 5'(a_reg);
                end
                a_reg <= a_reg + LVL_W'(1);
            end
            ST_H_WR: begin
                if (t_reg == '0 && x_reg == init_c) begin
                    result_reg     <= best_reg;
                    first_hire_reg <= best_a_reg;
                end
                if (x_reg == cap) begin
                    nxt_reg   <= ~nxt_reg;
                    first_reg <= 1'b0;
                    t_reg     <= t_reg - PER_W'(1);
                end else begin
                    x_reg <= x_reg + LVL_W'(1);
                end
            end
            ST_DONE:
                if (!m_valid_reg || m_ready) begin
                    m_data_reg.optimal_cost <= result_reg;
                    m_data_reg.first_hire   <= first_hire_reg;
                end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_leaver_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_E_C) |-> (i_reg <= y_reg && y_reg <= cap))
        else $error("leaver index past staff level");

    a_hire_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_H_CMP) |-> (a_reg != '0 && 5'(a_reg) <= hire_cap_reg))
        else $error("hire count out of range");

    a_addr_period: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_E_RD) |-> (addr_reg - period_base < ADDR_W'(PER_PERIOD)))
        else $error("turnover address left its period");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> !s_ready)
        else $error("request taken while result pending in sequencer");

endmodule

### hw/rtl/ssdp_weigh.sv
`timescale 1ns / 1ps
// Probability-times-cost unit: registered partial products, then rounding
// and saturation to a 48-bit cost. Depends on ssdp_pkg.
module ssdp_weigh import ssdp_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [PROB_W-1:0] prob,
    input  logic [COST_W-1:0] cost,
    output logic [COST_W-1:0] weighted
);

    logic [PROB_W+31:0] phi_reg;
    logic [PROB_W+15:0] plo_reg;
    logic [PROB_W+16:0] lo_round;
    logic [COST_W+1:0]  total;

    always_ff @(posedge aclk) begin
        if (en) begin
            phi_reg <= prob * cost[COST_W-1:16];
            plo_reg <= prob * cost[15:0];
        end
    end

    always_comb begin
        lo_round = (PROB_W+17)'(plo_reg) + (PROB_W+17)'(32'h8000);
        total    = (COST_W+2)'(phi_reg) + (COST_W+2)'(lo_round >> 16);
        weighted = (total > (COST_W+2)'(COST_MAX)) ? COST_MAX : total[COST_W-1:0];
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for stochastic_staffing_dp_unit: random and directed load/solve
// requests, with an in-bench dynamic program predictor scoring each result.
// Depends on ssdp_pkg and the RTL under hw/rtl.
module testbench;
    import ssdp_pkg::*;

    localparam int       STAFF_SPAN = MAX_LEVELS * (MAX_LEVELS + 1) / 2;
    localparam longint unsigned CEIL = 64'hFFFF_FFFF_FFFF;
    localparam int       LIMIT = 3_000_000;
    localparam int       IN_W = $bits(in_item_t);

    class staffing_scoreboard;
        logic [16:0]     turn_prob[MAX_PERIODS * STAFF_SPAN];
        logic [4:0]      min_level[MAX_PERIODS];
        logic [15:0]     fixed_cost, unit_cost, salary, penalty;
        logic [4:0]      staff_cap, hire_cap, period_count, init_staff;
        out_item_t       pending_results[$];
        int              failures;

        function new();
            foreach (turn_prob[k]) turn_prob[k] = '0;
            foreach (min_level[k]) min_level[k] = '0;
            fixed_cost = 0; unit_cost = 0; salary = 0; penalty = 0;
            staff_cap = 31; hire_cap = 31; period_count = 1; init_staff = 0;
            failures = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [15:0] v);
            case (idx)
                CFG_FIXED_HIRE: fixed_cost = v;
                CFG_HIRE_UNIT: unit_cost = v;
                CFG_SALARY: salary = v;
                CFG_SHORTAGE: penalty = v;
                CFG_STAFF_CAP: staff_cap = v[4:0];
                CFG_HIRE_CAP: hire_cap = v[4:0];
                CFG_PERIODS: period_count = v[4:0];
                default: init_staff = v[4:0];
            endcase
        endfunction

        function longint unsigned sat_sum(longint unsigned a, longint unsigned b);
            longint unsigned s;
            s = a + b;
            return s > CEIL ? CEIL : s;
        endfunction

        function longint unsigned weighted(longint unsigned p, longint unsigned c);
            longint unsigned t;
            t = p * (c >> 16) + ((p * (c & 64'hFFFF) + 64'h8000) >> 16);
            return t > CEIL ? CEIL : t;
        endfunction

        function out_item_t plan_staffing();
            longint unsigned nxt[MAX_LEVELS], cur[MAX_LEVELS], ex[MAX_LEVELS];
            longint unsigned acc, c, imm, best, v;
            int cap, periods, init, best_a, first, lvl, mn, short_by;
            out_item_t r;
            cap = staff_cap;
            periods = period_count > MAX_PERIODS ? MAX_PERIODS : period_count;
            init = init_staff > cap ? cap : init_staff;
            first = 0;
            foreach (nxt[k]) nxt[k] = 0;
            for (int t = periods - 1; t >= 0; t--) begin
                mn = min_level[t];
                for (int y = 0; y <= cap; y++) begin
                    acc = 0;
                    for (int i = 0; i <= y; i++) begin
                        lvl = y - i;
                        short_by = mn > lvl ? mn - lvl : 0;
                        imm = (longint'(salary) * lvl + longint'(penalty) * short_by) << 16;
                        c = sat_sum(imm, nxt[lvl]);
                        acc = sat_sum(acc,
                            weighted(turn_prob[t * STAFF_SPAN + y * (y + 1) / 2 + i], c));
                    end
                    ex[y] = acc;
                end
                for (int x = 0; x <= cap; x++) begin
                    best = ex[x];
                    best_a = 0;
                    for (int a = 1; a <= hire_cap; a++) begin
                        lvl = x + a > cap ? cap : x + a;
                        v = sat_sum((longint'(fixed_cost) + longint'(unit_cost) * a) << 16,
                                    ex[lvl]);
                        if (v < best) begin
                            best = v;
                            best_a = a;
                        end
                    end
                    cur[x] = best;
                    if (t == 0 && x == init) first = best_a;
                end
                nxt = cur;
            end
            r.optimal_cost = nxt[init][47:0];
            r.first_hire = first[4:0];
            return r;
        endfunction

        function void note_request(in_item_t it);
            logic [16:0] p;
            case (it.operation)
                OP_LOAD_PROB: begin
                    if (it.leavers <= it.staff_before) begin
                        p = it.probability > ONE_Q16 ? ONE_Q16 : it.probability;
                        turn_prob[it.period * STAFF_SPAN
                                  + it.staff_before * (it.staff_before + 1) / 2
                                  + it.leavers] = p;
                    end
                end
                OP_LOAD_MIN: min_level[it.period] = it.min_staff;
                OP_SOLVE: pending_results = {pending_results, plan_staffing()};
                default: ;
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result cost=%h hire=%0d", $time,
                         got.optimal_cost, got.first_hire);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.optimal_cost !== want.optimal_cost) begin
                $display("%0t: optimal_cost expected %h actual %h", $time,
                         want.optimal_cost, got.optimal_cost);
                failures++;
            end
            if (got.first_hire !== want.first_hire) begin
                $display("%0t: first_hire expected %0d actual %0d", $time,
                         want.first_hire, got.first_hire);
                failures++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    staffing_scoreboard sb = new();
    bit   prob_loaded[MAX_PERIODS * STAFF_SPAN];
    bit   min_loaded[MAX_PERIODS];
    bit   idle_on;
    int   rx_wait;
    int   cycles;

    stochastic_staffing_dp_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
                rx_wait = idle_on ? $urandom_range(16, 0) : 0;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(in_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(16, 0) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic configure(logic [15:0] fc, logic [15:0] uc, logic [15:0] sal,
                             logic [15:0] pen, logic [4:0] cap, logic [4:0] hcap,
                             logic [4:0] pc, logic [4:0] init);
        write_reg(CFG_FIXED_HIRE, fc);
        write_reg(CFG_HIRE_UNIT, uc);
        write_reg(CFG_SALARY, sal);
        write_reg(CFG_SHORTAGE, pen);
        write_reg(CFG_STAFF_CAP, {11'd0, cap});
        write_reg(CFG_HIRE_CAP, {11'd0, hcap});
        write_reg(CFG_PERIODS, {11'd0, pc});
        write_reg(CFG_INIT_STAFF, {11'd0, init});
        cfg_we <= 1'b0;
    endtask

    function automatic in_item_t prob_request(int t, int y, int i);
        in_item_t it;
        it = '0;
        it.operation    = OP_LOAD_PROB;
        it.period       = t[3:0];
        it.staff_before = y[4:0];
        it.leavers      = i[4:0];
        case ($urandom_range(5, 0))
            0: it.probability = ONE_Q16;
            1: it.probability = 17'($urandom_range(131071, 65537));
            default: it.probability = 17'($urandom_range(65535, 0));
        endcase
        it.min_staff = 5'($urandom);
        return it;
    endfunction

    function automatic in_item_t min_request(int t, int m);
        in_item_t it;
        it = in_item_t'(IN_W'({$urandom, $urandom}));
        it.operation = OP_LOAD_MIN;
        it.period    = t[3:0];
        it.min_staff = m[4:0];
        return it;
    endfunction

    function automatic in_item_t solve_request();
        in_item_t it;
        it = in_item_t'(IN_W'({$urandom, $urandom}));
        it.operation = OP_SOLVE;
        return it;
    endfunction

    task automatic fill_tables();
        int periods;
        in_item_t it;
        periods = sb.period_count > MAX_PERIODS ? MAX_PERIODS : sb.period_count;
        for (int t = 0; t < periods; t++) begin
            if (!min_loaded[t]) begin
                send_request(min_request(t, $urandom_range(31, 0)));
                min_loaded[t] = 1;
            end
            for (int y = 0; y <= sb.staff_cap; y++)
                for (int i = 0; i <= y; i++)
                    if (!prob_loaded[t * STAFF_SPAN + y * (y + 1) / 2 + i]) begin
                        it = prob_request(t, y, i);
                        send_request(it);
                        prob_loaded[t * STAFF_SPAN + y * (y + 1) / 2 + i] = 1;
                    end
        end
    endtask

    task automatic random_request();
        int t, y, i, pick;
        in_item_t it;
        pick = $urandom_range(99, 0);
        t = $urandom_range(15, 0);
        y = $urandom_range(31, 0);
        i = $urandom_range(y, 0);
        if (pick < 65) begin
            send_request(prob_request(t, y, i));
            prob_loaded[t * STAFF_SPAN + y * (y + 1) / 2 + i] = 1;
        end else if (pick < 80) begin
            send_request(min_request(t, $urandom_range(31, 0)));
            min_loaded[t] = 1;
        end else if (pick < 90) begin
            it = prob_request(t, 0, 0);
            it.staff_before = 5'($urandom_range(30, 0));
            it.leavers = 5'($urandom_range(31, it.staff_before + 1));
            send_request(it);
        end else begin
            it = in_item_t'(IN_W'({$urandom, $urandom}));
            it.operation = OP_NONE;
            send_request(it);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        idle_on   = 1'b1;
        rx_wait   = 0;
        cycles    = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(0, 0, 0, 0, 0, 0, 0, 0);
        send_request(solve_request());
        wait_idle();
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3, 31, 2, 9);
        send_request(min_request(0, 31));
        send_request(min_request(1, 0));
        min_loaded[0] = 1;
        min_loaded[1] = 1;
        fill_tables();
        send_request(solve_request());
        configure_keep: begin
            wait_idle();
            configure(7, 0, 100, 5000, 1, 0, 20, 2);
        end
        fill_tables();
        send_request(solve_request());
        wait_idle();
        idle_on = 1'b0;
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12, 31, 1, 31);
        fill_tables();
        send_request(solve_request());
        wait_idle();

        for (int ph = 0; ph < 25; ph++) begin
            idle_on = (ph % 4) != 1;
            configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      5'($urandom_range(6, 0)), 5'($urandom_range(31, 0)),
                      (ph % 7 == 3) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(5, 0)),
                      5'($urandom_range(31, 0)));
            if (ph % 7 == 3) write_reg(CFG_STAFF_CAP, 16'($urandom_range(2, 0)));
            cfg_we <= 1'b0;
            repeat (8) random_request();
            fill_tables();
            repeat ($urandom_range(3, 1)) send_request(solve_request());
            wait_idle();
        end

        if (sb.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
